// ===== rtl/core/cpd_pkg.sv =====
// package for the closest pair distance block
// holds sizes, types, the sequencer states and the coordinate conversion
// no dependencies
package cpd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;

  localparam int IN_W      = 16;
  localparam int SQ_W      = 33;
  localparam int DIST_W    = 25;
  localparam int FRAC_BITS = 8;

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W = COORD_BITS;
  localparam int SUM_W  = 2 * COORD_BITS + 1;
  localparam int BEST_W = (SUM_W > 34) ? SUM_W : 34;

  localparam int RAD_RAW = BEST_W + 2 * FRAC_BITS;
  localparam int RAD_W   = (RAD_RAW > 64) ? 64 : RAD_RAW + (RAD_RAW % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int STEP_W  = $clog2(ROOT_W + 1);

  localparam logic [BEST_W-1:0] BEST_NONE    = BEST_W'((64'd1 << 34) - 64'd1);
  localparam logic [SQ_W-1:0]   SQ_NONE      = '1;
  localparam logic [DIST_W-1:0] NO_PAIR_DIST = DIST_W'(64'd9999 << FRAC_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_OUT
  } state_t;

  // low COORD_BITS of the field, sign taken from bit COORD_BITS-1
  function automatic coord_t to_coord(input logic [IN_W-1:0] v);
    logic [IN_W+COORD_BITS-1:0] wide;
    wide = {{COORD_BITS{1'b0}}, v};
    return coord_t'(wide[COORD_BITS-1:0]);
  endfunction

endpackage

// ===== rtl/core/closest_pair_distance.sv =====
// closest pair of points: top level with sequencer, point store and result register
// depends on cpd_pkg, cpd_dist_unit, cpd_sqrt_unit
//
// usage:
//   input channel (in_valid / in_stall) takes one point per item, last_point marks
//   the end of a set. output channel (out_valid / out_stall) gives one item per set:
//   smallest squared distance, its square root with 8 fraction bits, and no_pair
//   when the set held fewer than two points (distance then reads 9999).
// timing:
//   a point arriving with n points stored holds in_stall until it has been compared:
//   the stored points are read one per cycle from the point memory and fed through
//   the single squared-distance unit (three stages after the registered read).
//   up to 64 points per set are stored and compared.
//   the last point of a set adds the square root, one root bit per cycle (25 bits),
//   then a done step and the result load; a set of one point adds only the result load.
//   points beyond 64 in a set are ignored apart from their end mark.
// reset: synchronous, clears the point count, best distance and output valid.
// stall: the result register holds while out_stall is high; the next set may be
//   taken meanwhile and waits in the final step until the register frees up.
module closest_pair_distance (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          x_coord,
  input  logic signed [15:0]          y_coord,
  input  logic                        last_point,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cpd_pkg::SQ_W-1:0]    min_dist_squared,
  output logic [cpd_pkg::DIST_W-1:0]  min_distance,
  output logic                        no_pair
);
  import cpd_pkg::*;

  state_t state, state_next;

  logic [2*COORD_BITS-1:0] pt_mem [MAX_POINTS];

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan_n;
  logic [IDX_W-1:0]  idx;
  logic [BEST_W-1:0] best;
  coord_t            cur_x, cur_y, rd_x, rd_y;
  logic              last_flag;
  logic              rd_vld;

  logic              accept, has_room, rd_en, sq_start, load_out;
  logic              d_valid, dist_busy, sq_done;
  logic [SUM_W-1:0]  d2;
  logic [BEST_W-1:0] d2_ext;
  logic [ROOT_W-1:0] root;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign has_room = count < CNT_W'(MAX_POINTS);
  assign d2_ext   = BEST_W'(d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    sq_start   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (has_room && count != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (CNT_W'(idx) == scan_n - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !dist_busy) begin
          if (!last_flag) begin
            state_next = ST_IDLE;
          end else if (count < CNT_W'(2)) begin
            state_next = ST_OUT;
          end else begin
            sq_start   = 1'b1;
            state_next = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // point store
  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      pt_mem[count[IDX_W-1:0]] <= {to_coord(x_coord), to_coord(y_coord)};
    end
    if (rd_en) begin
      {rd_x, rd_y} <= pt_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      best   <= BEST_NONE;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (load_out) begin
        count <= '0;
        best  <= BEST_NONE;
      end else begin
        if (accept && has_room) begin
          count <= count + CNT_W'(1);
        end
        if (d_valid && d2_ext < best) begin
          best <= d2_ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x     <= to_coord(x_coord);
      cur_y     <= to_coord(y_coord);
      last_flag <= last_point;
      scan_n    <= count;
      idx       <= '0;
    end else if (rd_en) begin
      idx <= idx + IDX_W'(1);
    end
  end

  cpd_dist_unit u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_vld),
    .ax       (cur_x),
    .ay       (cur_y),
    .bx       (rd_x),
    .by       (rd_y),
    .d_valid  (d_valid),
    .d2       (d2),
    .busy     (dist_busy)
  );

  cpd_sqrt_unit u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (RAD_W'({best, {(2 * FRAC_BITS){1'b0}}})),
    .done     (sq_done),
    .root     (root)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (count < CNT_W'(2)) begin
        min_dist_squared <= SQ_NONE;
        min_distance     <= NO_PAIR_DIST;
        no_pair          <= 1'b1;
      end else begin
        min_dist_squared <= SQ_W'(best);
        min_distance     <= DIST_W'(root);
        no_pair          <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/cpd_dist_unit.sv =====
// squared distance unit: abs difference, squares, sum in three stages
// one point pair enters per cycle
// depends on cpd_pkg
module cpd_dist_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  cpd_pkg::coord_t           ax,
  input  cpd_pkg::coord_t           ay,
  input  cpd_pkg::coord_t           bx,
  input  cpd_pkg::coord_t           by,
  output logic                      d_valid,
  output logic [cpd_pkg::SUM_W-1:0] d2,
  output logic                      busy
);
  import cpd_pkg::*;

  logic                       v1, v2;
  logic [DIFF_W-1:0]          dx, dy;
  logic [2*COORD_BITS-1:0]    sqx, sqy;
  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic signed [COORD_BITS:0] abs_x, abs_y;

  always_comb begin
    diff_x = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    diff_y = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
    abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
    abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      v1      <= in_valid;
      v2      <= v1;
      d_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx  <= abs_x[DIFF_W-1:0];
    dy  <= abs_y[DIFF_W-1:0];
    sqx <= dx * dx;
    sqy <= dy * dy;
    d2  <= SUM_W'(sqx) + SUM_W'(sqy);
  end

  assign busy = v1 | v2 | d_valid;

endmodule

// ===== rtl/core/cpd_sqrt_unit.sv =====
// iterative integer square root, one result bit per cycle
// restoring method on a shifted radicand
// depends on cpd_pkg
module cpd_sqrt_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cpd_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [cpd_pkg::ROOT_W-1:0] root
);
  import cpd_pkg::*;

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [ROOT_W+2:0] rem_sh, trial, rem_sub;
  logic              fits;

  always_comb begin
    rem_sh  = {rem, rad[RAD_W-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    rem_sub = rem_sh - trial;
    fits    = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
      steps <= STEP_W'(ROOT_W);
    end else if (busy) begin
      rad   <= rad << 2;
      steps <= steps - STEP_W'(1);
      if (fits) begin
        rem  <= rem_sub[ROOT_W:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[ROOT_W:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule
